### rtl/cns_pkg.sv
// ----------------------------------------------------------------------------
// cns_pkg - crop and nearest scale shared definitions
// Word types of the command and result channels, register indexes and the
// fixed field widths of the block.
// ----------------------------------------------------------------------------
package cns_pkg;

	localparam int PIXEL_W   = 32;
	localparam int COORD_W   = 18;	// signed Q2.16 crop edge
	localparam int FRAC_W    = 16;
	localparam int DIMREG_W  = 7;
	localparam int CFG_IDX_W = 3;
	localparam int EDGE_HALF = 32768;	// 0.5 in Q.16

	localparam logic [DIMREG_W-1:0] RST_SOURCE_WIDTH  = 7'd16;
	localparam logic [DIMREG_W-1:0] RST_SOURCE_HEIGHT = 7'd16;
	localparam logic [COORD_W-1:0]  RST_CROP_LEFT     = 18'd0;
	localparam logic [COORD_W-1:0]  RST_CROP_TOP      = 18'd0;
	localparam logic [COORD_W-1:0]  RST_CROP_RIGHT    = 18'd65536;
	localparam logic [COORD_W-1:0]  RST_CROP_BOTTOM   = 18'd65536;
	localparam logic [DIMREG_W-1:0] RST_TARGET_WIDTH  = 7'd16;
	localparam logic [DIMREG_W-1:0] RST_TARGET_HEIGHT = 7'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_CROP_LEFT     = 3'd2,
		REG_CROP_TOP      = 3'd3,
		REG_CROP_RIGHT    = 3'd4,
		REG_CROP_BOTTOM   = 3'd5,
		REG_TARGET_WIDTH  = 3'd6,
		REG_TARGET_HEIGHT = 3'd7
	} cns_reg_e;

	localparam logic CMD_STORE   = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [PIXEL_W-1:0] source_pixel;
	} cns_in_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] target_pixel;
		logic               last_pixel;
		logic               status;
	} cns_out_t;

endpackage

### rtl/cns_mul.sv
// ----------------------------------------------------------------------------
// cns_mul - shared signed multiplier
// One registered signed product per cycle; the sequencer steers the operands.
// ----------------------------------------------------------------------------
module cns_mul #(
	parameter int AW = 18,
	parameter int BW = 8
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	logic signed [AW+BW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### rtl/cns_div.sv
// ----------------------------------------------------------------------------
// cns_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cns_div #(
	parameter int ND = 13,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [ND-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [ND-1:0] quotient
);
	localparam int CW = $clog2(ND + 1);

	logic          run_q;
	logic [CW-1:0] cnt_q;
	logic [ND-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [DW:0]   shifted_c;
	logic [DW:0]   diff_c;
	logic          fits_c;

	always_comb begin
		shifted_c = {rem_q, quo_q[ND-1]};
		diff_c    = shifted_c - {1'b0, div_q};
		fits_c    = shifted_c >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(ND);
		end else if (run_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			// remainder stays below the divisor, so DW bits hold it
			rem_q <= fits_c ? diff_c[DW-1:0] : shifted_c[DW-1:0];
			quo_q <= {quo_q[ND-2:0], fits_c};
		end
	end

	assign busy     = run_q;
	assign quotient = quo_q;

endmodule

### rtl/cns_store.sv
// ----------------------------------------------------------------------------
// cns_store - source pixel memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module cns_store #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [cns_pkg::PIXEL_W-1:0] wdata,
	input  logic                       re,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [cns_pkg::PIXEL_W-1:0] rdata
);
	import cns_pkg::*;

	logic [PIXEL_W-1:0] mem_q [DEPTH];
	logic [PIXEL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/crop_and_nearest_scale_top.sv
// ----------------------------------------------------------------------------
// crop_and_nearest_scale_top - crop and nearest neighbor rescale
// Stores an RGBA source image in raster order, then returns one pixel of the
// cropped and rescaled target image per request word.
// Store word: passes through S_AREA and S_STORE back to idle, no result.
// Request word: the shared iterative divider, run at most once per axis,
// sets the pace. One word at a time.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset: asynchronous, active low; registers return to their reset values,
// positions to zero; the pixel memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module crop_and_nearest_scale_top #(
	parameter int MAX_SOURCE_DIM = 64,
	parameter int MAX_TARGET_DIM = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  cns_pkg::cns_in_t              item,
	output logic                          result_valid,
	output cns_pkg::cns_out_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cns_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cns_pkg::COORD_W-1:0]   cfg_data
);
	import cns_pkg::*;

	localparam int SDIM_W = $clog2(MAX_SOURCE_DIM + 1);
	localparam int TDIM_W = $clog2(MAX_TARGET_DIM + 1);
	localparam int TP_W   = $clog2(MAX_TARGET_DIM);
	localparam int IDX_W  = $clog2(MAX_SOURCE_DIM);
	localparam int DEPTH  = MAX_SOURCE_DIM * MAX_SOURCE_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int AREA_W = $clog2(DEPTH + 1);
	localparam int AW     = (COORD_W > SDIM_W + 1) ? COORD_W : SDIM_W + 1;
	localparam int BW     = SDIM_W + 1;
	localparam int PW     = AW + BW;
	localparam int E_W    = SDIM_W + 2;
	localparam int LW     = E_W + 1;
	localparam int ND     = TP_W + SDIM_W;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_AREA  = 16'h0002,
		S_STORE = 16'h0004,
		S_CHK   = 16'h0008,
		S_MLO   = 16'h0010,
		S_MHI   = 16'h0020,
		S_EHI   = 16'h0040,
		S_LEN   = 16'h0080,
		S_CUT   = 16'h0100,
		S_MPOS  = 16'h0200,
		S_DIVS  = 16'h0400,
		S_DIVW  = 16'h0800,
		S_IDX   = 16'h1000,
		S_ADDR  = 16'h2000,
		S_RDA   = 16'h4000,
		S_RDD   = 16'h8000
	} state_t;

	state_t state_q, state_n;

	// configuration registers
	logic [DIMREG_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [COORD_W-1:0]  crop_l_q, crop_t_q, crop_r_q, crop_b_q;

	// positions
	logic [ADDR_W-1:0] lp_q;
	logic [TP_W-1:0]   col_q, row_q;
	logic              axis_q;	// 0 column axis, 1 row axis

	// item and work registers
	cns_in_t                  item_q;
	logic signed [E_W-1:0]    e_lo_q, e_hi_q;
	logic signed [LW-1:0]     len_q;
	logic [E_W-2:0]           s0c_q;
	logic [SDIM_W-1:0]        len2_q;
	logic                     nodiv_q;
	logic [IDX_W-1:0]         ix_q, iy_q;

	// result register
	logic     valid_q;
	cns_out_t result_q;

	// clamped dimensions
	logic [SDIM_W-1:0] sw_c, sh_c, size_c;
	logic [TDIM_W-1:0] tw_c, th_c, tsize_c;
	logic [TP_W-1:0]   pos_c;
	logic [COORD_W-1:0] lo_c, hi_c;

	always_comb begin
		sw_c = (32'(src_w_q) > MAX_SOURCE_DIM) ? SDIM_W'(MAX_SOURCE_DIM) : SDIM_W'(src_w_q);
		sh_c = (32'(src_h_q) > MAX_SOURCE_DIM) ? SDIM_W'(MAX_SOURCE_DIM) : SDIM_W'(src_h_q);
		if (tgt_w_q == '0) begin
			tw_c = TDIM_W'(1);
		end else if (32'(tgt_w_q) > MAX_TARGET_DIM) begin
			tw_c = TDIM_W'(MAX_TARGET_DIM);
		end else begin
			tw_c = TDIM_W'(tgt_w_q);
		end
		if (tgt_h_q == '0) begin
			th_c = TDIM_W'(1);
		end else if (32'(tgt_h_q) > MAX_TARGET_DIM) begin
			th_c = TDIM_W'(MAX_TARGET_DIM);
		end else begin
			th_c = TDIM_W'(tgt_h_q);
		end
		size_c  = axis_q ? sh_c : sw_c;
		tsize_c = axis_q ? th_c : tw_c;
		pos_c   = axis_q ? row_q : col_q;
		lo_c    = axis_q ? crop_t_q : crop_l_q;
		hi_c    = axis_q ? crop_b_q : crop_r_q;
	end

	// shared multiplier
	logic signed [AW-1:0] mul_a_c;
	logic signed [BW-1:0] mul_b_c;
	logic signed [PW-1:0] p_q;

	always_comb begin
		mul_a_c = '0;
		mul_b_c = '0;
		case (state_q)
			S_AREA: begin
				mul_a_c = AW'(sw_c);
				mul_b_c = BW'(sh_c);
			end
			S_MLO: begin
				mul_a_c = AW'($signed(lo_c));
				mul_b_c = BW'(size_c);
			end
			S_MHI: begin
				mul_a_c = AW'($signed(hi_c));
				mul_b_c = BW'(size_c);
			end
			S_MPOS: begin
				mul_a_c = AW'(pos_c);
				mul_b_c = BW'(len2_q);
			end
			S_ADDR: begin
				mul_a_c = AW'(iy_q);
				mul_b_c = BW'(sw_c);
			end
			default: begin
				mul_a_c = '0;
				mul_b_c = '0;
			end
		endcase
	end

	cns_mul #(
		.AW (AW),
		.BW (BW)
	) u_mul (
		.clk (clk),
		.a   (mul_a_c),
		.b   (mul_b_c),
		.p   (p_q)
	);

	// crop edge: coord*size + 0.5, shifted with rounding toward zero
	logic signed [PW:0]        t_c;
	logic signed [PW-FRAC_W:0] t_hi_c;
	logic                      rnd_c;
	logic signed [E_W-1:0]     edge_c;

	always_comb begin
		t_c    = $signed({p_q[PW-1], p_q}) + $signed((PW+1)'(EDGE_HALF));
		t_hi_c = t_c[PW:FRAC_W];
		rnd_c  = t_c[PW] && (t_c[FRAC_W-1:0] != '0);
		edge_c = E_W'(t_hi_c) + E_W'(rnd_c);
	end

	// crop length and start
	logic signed [LW-1:0] len_c;
	logic                 empty_c;
	logic [E_W-2:0]       s0c_c;
	logic signed [LW:0]   sum_c, size_s_c, rest_c, len2_c;
	logic                 over_c;

	always_comb begin
		len_c    = LW'(e_hi_q) - LW'(e_lo_q);
		empty_c  = len_c[LW-1] || (len_c == '0);
		s0c_c    = e_lo_q[E_W-1] ? '0 : (E_W-1)'(e_lo_q);
		sum_c    = $signed((LW+1)'(s0c_q)) + (LW+1)'(len_q);
		size_s_c = $signed((LW+1)'(size_c));
		rest_c   = size_s_c - $signed((LW+1)'(s0c_q));
		over_c   = sum_c > size_s_c;
		len2_c   = over_c ? rest_c : (LW+1)'(len_q);
	end

	// divider
	logic          div_busy;
	logic [ND-1:0] quo;

	cns_div #(
		.ND (ND),
		.DW (TDIM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIVS),
		.dividend (ND'(p_q)),
		.divisor  (tsize_c),
		.busy     (div_busy),
		.quotient (quo)
	);

	// source index for the current axis
	logic [SDIM_W:0]  pick_c;
	logic [IDX_W-1:0] idx_c;

	always_comb begin
		pick_c = (SDIM_W+1)'(s0c_q) + (SDIM_W+1)'(quo[SDIM_W-1:0]);
		if (nodiv_q || (pick_c >= (SDIM_W+1)'(size_c))) begin
			idx_c = IDX_W'(size_c - SDIM_W'(1));
		end else begin
			idx_c = IDX_W'(pick_c);
		end
	end

	// load position and memory
	logic [AREA_W-1:0] area_c, st_next_c;
	logic              area_zero_c;
	logic [ADDR_W-1:0] st_addr_c, rd_addr_c;
	logic [PIXEL_W-1:0] rd_data;

	always_comb begin
		area_c      = AREA_W'(p_q);
		area_zero_c = (area_c == '0);
		st_addr_c   = (AREA_W'(lp_q) >= area_c) ? '0 : lp_q;
		st_next_c   = AREA_W'(st_addr_c) + AREA_W'(1);
		rd_addr_c   = ADDR_W'(p_q) + ADDR_W'(ix_q);
	end

	cns_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    ((state_q == S_STORE) && !area_zero_c),
		.waddr (st_addr_c),
		.wdata (item_q.source_pixel),
		.re    (state_q == S_RDA),
		.raddr (rd_addr_c),
		.rdata (rd_data)
	);

	// output position advance
	logic [TDIM_W-1:0] col_n_c, row_n_c;

	always_comb begin
		col_n_c = TDIM_W'(col_q) + TDIM_W'(1);
		row_n_c = TDIM_W'(row_q) + TDIM_W'(1);
	end

	// sequencer
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_n = S_AREA;
			S_AREA:  state_n = (item_q.cmd == CMD_REQUEST) ? S_CHK : S_STORE;
			S_STORE: state_n = S_IDLE;
			S_CHK:   state_n = area_zero_c ? S_IDLE : S_MLO;
			S_MLO:   state_n = S_MHI;
			S_MHI:   state_n = S_EHI;
			S_EHI:   state_n = S_LEN;
			S_LEN:   state_n = empty_c ? S_IDLE : S_CUT;
			S_CUT:   state_n = (len2_c[LW] || (len2_c == '0)) ? S_IDX : S_MPOS;
			S_MPOS:  state_n = S_DIVS;
			S_DIVS:  state_n = S_DIVW;
			S_DIVW:  if (!div_busy) state_n = S_IDX;
			S_IDX:   state_n = axis_q ? S_ADDR : S_MLO;
			S_ADDR:  state_n = S_RDA;
			S_RDA:   state_n = S_RDD;
			S_RDD:   state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			valid_q  <= 1'b0;
			axis_q   <= 1'b0;
			lp_q     <= '0;
			col_q    <= '0;
			row_q    <= '0;
			src_w_q  <= RST_SOURCE_WIDTH;
			src_h_q  <= RST_SOURCE_HEIGHT;
			crop_l_q <= RST_CROP_LEFT;
			crop_t_q <= RST_CROP_TOP;
			crop_r_q <= RST_CROP_RIGHT;
			crop_b_q <= RST_CROP_BOTTOM;
			tgt_w_q  <= RST_TARGET_WIDTH;
			tgt_h_q  <= RST_TARGET_HEIGHT;
		end else begin
			state_q <= state_n;
			valid_q <= ((state_q == S_CHK) && area_zero_c) ||
				((state_q == S_LEN) && empty_c) || (state_q == S_RDD);

			if (cfg_valid && cfg_ready) begin
				unique case (cns_reg_e'(cfg_index))
					REG_SOURCE_WIDTH:  src_w_q  <= cfg_data[DIMREG_W-1:0];
					REG_SOURCE_HEIGHT: src_h_q  <= cfg_data[DIMREG_W-1:0];
					REG_CROP_LEFT:     crop_l_q <= cfg_data;
					REG_CROP_TOP:      crop_t_q <= cfg_data;
					REG_CROP_RIGHT:    crop_r_q <= cfg_data;
					REG_CROP_BOTTOM:   crop_b_q <= cfg_data;
					REG_TARGET_WIDTH:  tgt_w_q  <= cfg_data[DIMREG_W-1:0];
					REG_TARGET_HEIGHT: tgt_h_q  <= cfg_data[DIMREG_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				S_AREA: begin
					axis_q <= 1'b0;
					// restart positions left out of range by a register change
					if (item_q.cmd == CMD_REQUEST) begin
						if (TDIM_W'(col_q) >= tw_c) col_q <= '0;
						if (TDIM_W'(row_q) >= th_c) row_q <= '0;
					end
				end
				S_STORE: begin
					if (!area_zero_c) begin
						lp_q <= (st_next_c >= area_c) ? '0 : ADDR_W'(st_next_c);
					end
				end
				S_IDX: begin
					axis_q <= 1'b1;
				end
				S_RDD: begin
					if (col_n_c >= tw_c) begin
						col_q <= '0;
						row_q <= (row_n_c >= th_c) ? '0 : TP_W'(row_n_c);
					end else begin
						col_q <= TP_W'(col_n_c);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			item_q <= item;
		end
		if (state_q == S_MHI) e_lo_q <= edge_c;
		if (state_q == S_EHI) e_hi_q <= edge_c;
		if (state_q == S_LEN) begin
			len_q <= len_c;
			s0c_q <= s0c_c;
		end
		if (state_q == S_CUT) begin
			len2_q  <= SDIM_W'(len2_c);
			nodiv_q <= len2_c[LW] || (len2_c == '0);
		end
		if (state_q == S_IDX) begin
			if (axis_q) begin
				iy_q <= idx_c;
			end else begin
				ix_q <= idx_c;
			end
		end

		// empty source or empty crop: no image
		if (((state_q == S_CHK) && area_zero_c) || ((state_q == S_LEN) && empty_c)) begin
			result_q.target_pixel <= '0;
			result_q.last_pixel   <= 1'b0;
			result_q.status       <= 1'b1;
		end else if (state_q == S_RDD) begin
			result_q.target_pixel <= rd_data;
			result_q.last_pixel   <= (col_n_c >= tw_c) && (row_n_c >= th_c);
			result_q.status       <= 1'b0;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = (state_q == S_IDLE);
	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

### rtl/cns_chk.sv
// ----------------------------------------------------------------------------
// cns_chk - port level checks for crop_and_nearest_scale_top
// Watches the command, result and configuration ports over time.
// ----------------------------------------------------------------------------
module cns_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input cns_pkg::cns_in_t              item,
	input logic                          result_valid,
	input cns_pkg::cns_out_t             result,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [cns_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cns_pkg::COORD_W-1:0]   cfg_data
);
	import cns_pkg::*;

	// an accepted word keeps the block busy and gives no word at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !result_valid))
		else $error("accepted word did not occupy the block");

	// a result word is shown with the block already idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result word while busy");

	// each result word lasts exactly one cycle
	a_result_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// an error word carries no pixel and no end mark
	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status) |-> ((result.target_pixel == '0) && !result.last_pixel))
		else $error("error word with pixel data or end mark");

	// configuration is taken only while idle
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> (!busy && !(start && result_valid && busy)))
		else $error("configuration word taken while busy");

endmodule

bind crop_and_nearest_scale_top cns_chk u_cns_chk (.*);

### verif/crop_and_nearest_scale_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crop_and_nearest_scale_top_tb - self-checking bench for crop and scale
// Loads source images through the command port and requests target pixels.
// A scoreboard class keeps its own copy of the pixel memory, positions and
// registers, predicts each result word and compares it field by field.
// Directed phases cover the special crop and size cases. Random phases then
// mix register settings, stores and requests with bursts of idle cycles.
// ----------------------------------------------------------------------------

import cns_pkg::*;

class scale_scoreboard;
	int src_max = 64;
	int tgt_max = 64;

	logic [DIMREG_W-1:0] src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
	logic [COORD_W-1:0]  left_reg, top_reg, right_reg, bottom_reg;

	logic [PIXEL_W-1:0] pixel_mem [4096];
	bit                 loaded [4096];
	int unsigned        load_pos, out_col, out_row;

	cns_out_t    expected_pixels[$];
	int unsigned mismatches;

	function new();
		src_w_reg  = RST_SOURCE_WIDTH;
		src_h_reg  = RST_SOURCE_HEIGHT;
		tgt_w_reg  = RST_TARGET_WIDTH;
		tgt_h_reg  = RST_TARGET_HEIGHT;
		left_reg   = RST_CROP_LEFT;
		top_reg    = RST_CROP_TOP;
		right_reg  = RST_CROP_RIGHT;
		bottom_reg = RST_CROP_BOTTOM;
		load_pos   = 0;
		out_col    = 0;
		out_row    = 0;
		mismatches = 0;
		foreach (loaded[i]) loaded[i] = 1'b0;
	endfunction

	function void write_reg(cns_reg_e r, logic [COORD_W-1:0] d);
		case (r)
			REG_SOURCE_WIDTH:  src_w_reg  = d[DIMREG_W-1:0];
			REG_SOURCE_HEIGHT: src_h_reg  = d[DIMREG_W-1:0];
			REG_CROP_LEFT:     left_reg   = d;
			REG_CROP_TOP:      top_reg    = d;
			REG_CROP_RIGHT:    right_reg  = d;
			REG_CROP_BOTTOM:   bottom_reg = d;
			REG_TARGET_WIDTH:  tgt_w_reg  = d[DIMREG_W-1:0];
			REG_TARGET_HEIGHT: tgt_h_reg  = d[DIMREG_W-1:0];
			default: ;
		endcase
	endfunction

	function int src_dim(logic [DIMREG_W-1:0] v);
		return (int'(v) > src_max) ? src_max : int'(v);
	endfunction

	function int tgt_dim(logic [DIMREG_W-1:0] v);
		if (v == 0) return 1;
		return (int'(v) > tgt_max) ? tgt_max : int'(v);
	endfunction

	// round half up, then truncate toward zero
	function int crop_edge(logic [COORD_W-1:0] raw, int size);
		longint c, t;
		c = longint'($signed(raw));
		t = c * size + EDGE_HALF;
		if (t >= 0) return int'(t >>> FRAC_W);
		return -int'((-t) >>> FRAC_W);
	endfunction

	function bit axis_pick(logic [COORD_W-1:0] lo, logic [COORD_W-1:0] hi, int size,
			int tsize, int pos, output int idx);
		int s0, s1, len;
		s0  = crop_edge(lo, size);
		s1  = crop_edge(hi, size);
		len = s1 - s0;
		idx = 0;
		if (len <= 0) return 1'b0;
		if (s0 < 0) s0 = 0;
		if (s0 + len > size) len = size - s0;
		if (len <= 0) begin
			idx = size - 1;
		end else begin
			idx = s0 + (pos * len) / tsize;
			if (idx >= size) idx = size - 1;
		end
		return 1'b1;
	endfunction

	function int area();
		return src_dim(src_w_reg) * src_dim(src_h_reg);
	endfunction

	function bit source_ready();
		for (int i = 0; i < area(); i++)
			if (!loaded[i]) return 1'b0;
		return 1'b1;
	endfunction

	function void note_word(cns_in_t w);
		int sw, sh, tw, th, ix, iy, sz;
		bit ok;
		cns_out_t r;
		sw = src_dim(src_w_reg);
		sh = src_dim(src_h_reg);
		tw = tgt_dim(tgt_w_reg);
		th = tgt_dim(tgt_h_reg);
		sz = sw * sh;
		if (w.cmd == CMD_STORE) begin
			if (sz == 0) return;
			if (load_pos >= sz) load_pos = 0;
			pixel_mem[load_pos] = w.source_pixel;
			loaded[load_pos] = 1'b1;
			load_pos++;
			if (load_pos >= sz) load_pos = 0;
			return;
		end
		if (out_col >= tw) out_col = 0;
		if (out_row >= th) out_row = 0;
		ok = (sw > 0) && (sh > 0);
		if (ok) ok = axis_pick(left_reg, right_reg, sw, tw, int'(out_col), ix);
		if (ok) ok = axis_pick(top_reg, bottom_reg, sh, th, int'(out_row), iy);
		r = '0;
		if (!ok) begin
			r.status = 1'b1;
		end else begin
			r.target_pixel = pixel_mem[iy * sw + ix];
			if (out_col + 1 >= tw) begin
				out_col = 0;
				if (out_row + 1 >= th) begin
					out_row = 0;
					r.last_pixel = 1'b1;
				end else begin
					out_row++;
				end
			end else begin
				out_col++;
			end
		end
		expected_pixels.push_back(r);
	endfunction

	function void check_result(cns_out_t got);
		cns_out_t want;
		if (expected_pixels.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word: pixel %08h last %0b status %0b",
					got.target_pixel, got.last_pixel, got.status);
			return;
		end
		want = expected_pixels.pop_front();
		if (got.target_pixel !== want.target_pixel || got.last_pixel !== want.last_pixel ||
				got.status !== want.status) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: want pixel %08h last %0b status %0b, got pixel %08h last %0b status %0b",
					want.target_pixel, want.last_pixel, want.status,
					got.target_pixel, got.last_pixel, got.status);
		end
	endfunction
endclass

module crop_and_nearest_scale_top_tb;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	cns_in_t              item = '0;
	logic                 result_valid;
	cns_out_t             result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data = '0;

	scale_scoreboard sb;
	logic [COORD_W-1:0] regs [8];
	bit gaps_on;
	int random_words;

	crop_and_nearest_scale_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(result);
	end

	task automatic send_word(logic cmd, logic [PIXEL_W-1:0] px);
		cns_in_t w;
		w.cmd = cmd;
		w.source_pixel = px;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		do @(posedge clk); while (busy);
		sb.note_word(w);
	endtask

	// drop start, drain all results and let a trailing store finish
	task automatic settle();
		start <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		do @(posedge clk); while (busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_regs();
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cns_reg_e'(i);
			cfg_data  <= regs[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(cns_reg_e'(i), regs[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// write every entry that requests can reach before any request
	task automatic fill_source();
		if (sb.area() > 0 && !sb.source_ready())
			repeat (sb.area()) send_word(CMD_STORE, $urandom);
	endtask

	task automatic requests(int n);
		repeat (n) send_word(CMD_REQUEST, $urandom);
	endtask

	function automatic logic [COORD_W-1:0] rand_dim();
		int p;
		logic [DIMREG_W-1:0] v;
		p = $urandom_range(0, 19);
		if (p < 13)       v = DIMREG_W'($urandom_range(1, 8));
		else if (p < 15)  v = DIMREG_W'($urandom_range(9, 63));
		else if (p == 15) v = DIMREG_W'(64);
		else if (p == 16) v = '0;
		else              v = DIMREG_W'($urandom_range(65, 127));
		// upper data bits are don't-care for size registers
		if ($urandom_range(0, 3) == 0)
			return {11'($urandom), v};
		return {11'd0, v};
	endfunction

	function automatic int clamp_coord(int v);
		if (v < -131072) return -131072;
		if (v > 131071) return 131071;
		return v;
	endfunction

	task automatic rand_crop(output logic [COORD_W-1:0] lo, output logic [COORD_W-1:0] hi);
		int p, a, b;
		p = $urandom_range(0, 9);
		if (p < 6) begin
			a = int'($urandom_range(0, 90000)) - 20000;
			b = a + int'($urandom_range(1, 90000));
		end else if (p == 6) begin
			a = int'($urandom_range(0, 262143)) - 131072;
			b = a - int'($urandom_range(0, 2000));
		end else if (p == 7) begin
			a = -131072;
			b = $urandom_range(0, 1) ? 131071 : 65536;
		end else if (p == 8) begin
			a = $urandom_range(65536, 120000);
			b = a + int'($urandom_range(1, 40000));
		end else begin
			a = int'($urandom_range(0, 262143)) - 131072;
			b = int'($urandom_range(0, 262143)) - 131072;
		end
		lo = COORD_W'(clamp_coord(a));
		hi = COORD_W'(clamp_coord(b));
	endtask

	task automatic random_phase();
		int n;
		regs[REG_SOURCE_WIDTH]  = rand_dim();
		regs[REG_SOURCE_HEIGHT] = rand_dim();
		// keep the source small so that loading it stays short
		while (sb.src_dim(regs[REG_SOURCE_WIDTH][DIMREG_W-1:0]) *
				sb.src_dim(regs[REG_SOURCE_HEIGHT][DIMREG_W-1:0]) > 256)
			regs[REG_SOURCE_HEIGHT] = rand_dim();
		regs[REG_TARGET_WIDTH]  = rand_dim();
		regs[REG_TARGET_HEIGHT] = rand_dim();
		rand_crop(regs[REG_CROP_LEFT], regs[REG_CROP_RIGHT]);
		rand_crop(regs[REG_CROP_TOP], regs[REG_CROP_BOTTOM]);
		apply_regs();
		gaps_on = (random_words < 340) && ($urandom_range(0, 3) != 0);
		if (sb.area() > 0 && !sb.source_ready()) random_words += sb.area();
		fill_source();
		n = $urandom_range(4, 40);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 3) == 0) send_word(CMD_STORE, $urandom);
			else                           send_word(CMD_REQUEST, $urandom);
		end
		random_words += n;
		settle();
	endtask

	initial begin
		sb = new();
		random_words = 0;
		gaps_on = 1'b1;
		regs[REG_SOURCE_WIDTH]  = COORD_W'(RST_SOURCE_WIDTH);
		regs[REG_SOURCE_HEIGHT] = COORD_W'(RST_SOURCE_HEIGHT);
		regs[REG_CROP_LEFT]     = RST_CROP_LEFT;
		regs[REG_CROP_TOP]      = RST_CROP_TOP;
		regs[REG_CROP_RIGHT]    = RST_CROP_RIGHT;
		regs[REG_CROP_BOTTOM]   = RST_CROP_BOTTOM;
		regs[REG_TARGET_WIDTH]  = COORD_W'(RST_TARGET_WIDTH);
		regs[REG_TARGET_HEIGHT] = COORD_W'(RST_TARGET_HEIGHT);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2 source upscaled to 3x3, one full frame plus the wrap
		regs[REG_SOURCE_WIDTH]  = 18'd2;
		regs[REG_SOURCE_HEIGHT] = 18'd2;
		regs[REG_TARGET_WIDTH]  = 18'd3;
		regs[REG_TARGET_HEIGHT] = 18'd3;
		apply_regs();
		send_word(CMD_STORE, 32'h0000_0000);
		send_word(CMD_STORE, 32'hFFFF_FFFF);
		send_word(CMD_STORE, 32'h5555_5555);
		send_word(CMD_STORE, 32'hAAAA_AAAA);
		requests(10);
		settle();

		// empty crop: zero width, then bottom above top
		regs[REG_CROP_RIGHT] = 18'd0;
		apply_regs();
		requests(1);
		settle();
		regs[REG_CROP_RIGHT]  = 18'd65536;
		regs[REG_CROP_BOTTOM] = -18'sd65536;
		apply_regs();
		send_word(CMD_STORE, 32'h1234_5678);
		requests(1);
		settle();

		// empty source: the store is dropped, the request flags an error
		regs[REG_CROP_BOTTOM]  = 18'd65536;
		regs[REG_SOURCE_WIDTH] = 18'd0;
		apply_regs();
		send_word(CMD_STORE, 32'hDEAD_BEEF);
		requests(1);
		settle();

		// oversize source width and target height, zero target width
		regs[REG_SOURCE_WIDTH]  = 18'd100;
		regs[REG_SOURCE_HEIGHT] = 18'd1;
		regs[REG_TARGET_WIDTH]  = 18'd0;
		regs[REG_TARGET_HEIGHT] = 18'd100;
		apply_regs();
		fill_source();
		requests(3);
		settle();

		// crop edges at the extremes of the coordinate range
		regs[REG_CROP_LEFT]   = -18'sd131072;
		regs[REG_CROP_RIGHT]  = 18'd131071;
		regs[REG_CROP_TOP]    = -18'sd131072;
		regs[REG_CROP_BOTTOM] = 18'd131071;
		apply_regs();
		requests(2);
		settle();

		// crop start past the source edge: index pins to the last column
		regs[REG_CROP_LEFT] = 18'd98304;
		apply_regs();
		requests(2);
		settle();

		while (random_words < 420) random_phase();

		settle();
		repeat (80) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

### crop_and_nearest_scale_top.f
rtl/cns_pkg.sv
rtl/cns_mul.sv
rtl/cns_div.sv
rtl/cns_store.sv
rtl/crop_and_nearest_scale_top.sv
rtl/cns_chk.sv
verif/crop_and_nearest_scale_top_tb.sv
